>>> src/g2f_pkg.sv
// ----------------------------------------------------------------------------
// g2f_pkg
// Types, widths, stage map and fixed-point helpers for the 2D Gaussian
// fusion pipeline (signed Q16.16 arithmetic).
// ----------------------------------------------------------------------------
package g2f_pkg;

	localparam int QW      = 32;              // Q16.16 word
	localparam int FRAC    = 16;              // fraction bits
	localparam int PRODW   = 2 * QW;          // exact product
	localparam int RNDW    = PRODW - FRAC;    // rounded product
	localparam int DETW    = RNDW + 1;        // determinant
	localparam int MAGW    = DETW - 1;        // divider magnitudes
	localparam int NUMW    = QW + 1;          // negated matrix entry
	localparam int SUMW    = RNDW + 2;        // sum before saturation
	localparam int QBITS   = QW;              // quotient bits
	localparam int DIV_BPS = 4;               // quotient bits per stage
	localparam int DIV_NST = QBITS / DIV_BPS; // iteration stages
	localparam int DIV_LAT = DIV_NST + 2;     // plus setup and sign stages

	// stage map of the top level (register index, 1 = first)
	localparam int ST_DET = 2;                 // input determinants
	localparam int ST_INV = ST_DET + DIV_LAT;  // input inverses
	localparam int ST_L   = ST_INV + 1;        // information sum
	localparam int ST_MV  = ST_L + 1;          // information vectors
	localparam int ST_V   = ST_MV + 1;         // summed vector, det of sum
	localparam int ST_P   = ST_V + DIV_LAT;    // fused covariance
	localparam int ST_OUT = ST_P + 2;          // fused mean, output register

	typedef logic signed [QW-1:0]    q_t;
	typedef logic signed [DETW-1:0]  det_t;
	typedef logic signed [NUMW-1:0]  num_t;
	typedef logic signed [SUMW-1:0]  sum_t;
	typedef logic [3:0][QW-1:0]      mat_t;

	typedef struct packed {
		q_t   val;
		logic sat;
	} sat_t;

	typedef struct packed {
		q_t first_mean_x;
		q_t first_mean_y;
		q_t first_cov_xx;
		q_t first_cov_xy;
		q_t first_cov_yx;
		q_t first_cov_yy;
		q_t second_mean_x;
		q_t second_mean_y;
		q_t second_cov_xx;
		q_t second_cov_xy;
		q_t second_cov_yx;
		q_t second_cov_yy;
	} est_t;

	typedef struct packed {
		q_t   fused_mean_x;
		q_t   fused_mean_y;
		q_t   fused_cov_xx;
		q_t   fused_cov_xy;
		q_t   fused_cov_yx;
		q_t   fused_cov_yy;
		logic bad_result;
	} fused_t;

	// values that ride along the pipeline next to the arithmetic units
	typedef struct packed {
		q_t   m1x;
		q_t   m1y;
		q_t   m2x;
		q_t   m2y;
		mat_t c1;
		mat_t c2;
		mat_t l;
		q_t   vx;
		q_t   vy;
		mat_t p;
		logic sing;
		logic bad;
	} side_t;

	// round a Q32.32 product to Q32.16, ties toward plus infinity
	function automatic logic signed [RNDW-1:0] qrnd(input logic signed [PRODW-1:0] p);
		logic signed [PRODW:0] t;
		t = $signed({p[PRODW-1], p}) + $signed((PRODW+1)'(1 << (FRAC - 1)));
		return t[PRODW-1:FRAC];
	endfunction

	// clamp to the Q16.16 range and flag the clamp
	function automatic sat_t sat32(input sum_t v);
		sat_t r;
		r.sat = 1'b0;
		r.val = v[QW-1:0];
		if (v > $signed(SUMW'({1'b0, {(QW-1){1'b1}}}))) begin
			r.val = {1'b0, {(QW-1){1'b1}}};
			r.sat = 1'b1;
		end else if (v < $signed({{(SUMW-QW+1){1'b1}}, {(QW-1){1'b0}}})) begin
			r.val = {1'b1, {(QW-1){1'b0}}};
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage

>>> src/g2f_if.sv
// ----------------------------------------------------------------------------
// g2f_if
// Valid/ready channels for estimate pairs and fused results.
// ----------------------------------------------------------------------------
interface g2f_est_if;
	import g2f_pkg::*;
	logic valid;
	logic ready;
	est_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface g2f_fused_if;
	import g2f_pkg::*;
	logic   valid;
	logic   ready;
	fused_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> src/g2f_det.sv
// ----------------------------------------------------------------------------
// g2f_det
// Two-stage 2x2 determinant: exact products, then round and subtract.
// ----------------------------------------------------------------------------
module g2f_det (
	input  logic           clk,
	input  logic [1:0]     en,
	input  g2f_pkg::q_t    a,
	input  g2f_pkg::q_t    b,
	input  g2f_pkg::q_t    c,
	input  g2f_pkg::q_t    d,
	output g2f_pkg::det_t  det
);
	import g2f_pkg::*;

	logic signed [PRODW-1:0] ad_s1, bc_s1;
	logic signed [RNDW-1:0]  rad, rbc;

	// form the cross products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			ad_s1 <= a * d;
			bc_s1 <= b * c;
		end
	end

	// round each product and take the difference
	assign rad = qrnd(ad_s1);
	assign rbc = qrnd(bc_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			det <= $signed({rad[RNDW-1], rad}) - $signed({rbc[RNDW-1], rbc});
		end
	end

endmodule

>>> src/g2f_div.sv
// ----------------------------------------------------------------------------
// g2f_div
// Pipelined signed divide of (num * 2^16) by den, truncating toward zero,
// with the quotient clamped to Q16.16. Restoring division, a few bits a stage.
// ----------------------------------------------------------------------------
module g2f_div (
	input  logic                         clk,
	input  logic [g2f_pkg::DIV_LAT-1:0]  en,
	input  g2f_pkg::num_t                num,
	input  g2f_pkg::det_t                den,
	output g2f_pkg::q_t                  res,
	output logic                         sat
);
	import g2f_pkg::*;

	localparam int WW = MAGW + QBITS;

	logic [MAGW-1:0]  rem_q [DIV_NST+1];
	logic [MAGW-1:0]  ad_q  [DIV_NST+1];
	logic [QBITS-1:0] quo_q [DIV_NST+1];
	logic             neg_q [DIV_NST+1];
	logic             ovf_q [DIV_NST+1];

	logic [NUMW-1:0]  an_full;
	logic [DETW-1:0]  ad_full;
	logic [MAGW-1:0]  an, ad;
	logic [MAGW-1:0]  rem_n [1:DIV_NST];
	logic [QBITS-1:0] quo_n [1:DIV_NST];
	logic [QBITS:0]   negq;

	// take magnitudes, detect a quotient of 2^32 or more
	always_comb begin
		an_full = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
		ad_full = den[DETW-1] ? DETW'(-den) : DETW'(den);
		an      = {an_full[QW-1:0], {FRAC{1'b0}}};
		ad      = ad_full[MAGW-1:0];
	end

	// retire DIV_BPS quotient bits per stage, most significant first
	always_comb begin
		logic [WW-1:0] sh;
		for (int s = 1; s <= DIV_NST; s++) begin
			rem_n[s] = rem_q[s-1];
			quo_n[s] = quo_q[s-1];
			for (int j = 0; j < DIV_BPS; j++) begin
				sh = WW'(ad_q[s-1]) << (QBITS - 1 - ((s - 1) * DIV_BPS + j));
				if ({{QBITS{1'b0}}, rem_n[s]} >= sh) begin
					rem_n[s] = rem_n[s] - sh[MAGW-1:0];
					quo_n[s] = quo_n[s] |
						(QBITS'(1) << (QBITS - 1 - ((s - 1) * DIV_BPS + j)));
				end
			end
		end
	end

	// load the setup stage, then advance the iteration stages
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_q[0] <= an;
			ad_q[0]  <= ad;
			quo_q[0] <= '0;
			neg_q[0] <= num[NUMW-1] ^ den[DETW-1];
			ovf_q[0] <= {ad, {QBITS{1'b0}}} <= {{QBITS{1'b0}}, an};
		end
		for (int s = 1; s <= DIV_NST; s++) begin
			if (en[s]) begin
				rem_q[s] <= rem_n[s];
				quo_q[s] <= quo_n[s];
				ad_q[s]  <= ad_q[s-1];
				neg_q[s] <= neg_q[s-1];
				ovf_q[s] <= ovf_q[s-1];
			end
		end
	end

	// apply the sign and clamp
	assign negq = -{1'b0, quo_q[DIV_NST]};

	always_ff @(posedge clk) begin
		if (en[DIV_NST+1]) begin
			if (!neg_q[DIV_NST]) begin
				if (ovf_q[DIV_NST] || quo_q[DIV_NST][QBITS-1]) begin
					res <= {1'b0, {(QW-1){1'b1}}};
					sat <= 1'b1;
				end else begin
					res <= quo_q[DIV_NST];
					sat <= 1'b0;
				end
			end else begin
				if (ovf_q[DIV_NST] || quo_q[DIV_NST] > {1'b1, {(QBITS-1){1'b0}}}) begin
					res <= {1'b1, {(QW-1){1'b0}}};
					sat <= 1'b1;
				end else begin
					res <= negq[QBITS-1:0];
					sat <= 1'b0;
				end
			end
		end
	end

endmodule

>>> src/g2f_mv.sv
// ----------------------------------------------------------------------------
// g2f_mv
// Two-stage 2x2 matrix times vector in Q16.16 with clamped sums.
// ----------------------------------------------------------------------------
module g2f_mv (
	input  logic          clk,
	input  logic [1:0]    en,
	input  g2f_pkg::mat_t m,
	input  g2f_pkg::q_t   x,
	input  g2f_pkg::q_t   y,
	output g2f_pkg::q_t   ox,
	output g2f_pkg::q_t   oy,
	output logic          sat
);
	import g2f_pkg::*;

	logic signed [PRODW-1:0] p_s1 [4];
	logic signed [RNDW-1:0]  r    [4];
	sat_t                    sx, sy;

	// four exact products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s1[0] <= $signed(m[0]) * x;
			p_s1[1] <= $signed(m[1]) * y;
			p_s1[2] <= $signed(m[2]) * x;
			p_s1[3] <= $signed(m[3]) * y;
		end
	end

	// round, add pairwise, clamp
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			r[k] = qrnd(p_s1[k]);
		end
		sx = sat32(SUMW'(r[0]) + SUMW'(r[1]));
		sy = sat32(SUMW'(r[2]) + SUMW'(r[3]));
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ox  <= sx.val;
			oy  <= sy.val;
			sat <= sx.sat | sy.sat;
		end
	end

endmodule

>>> src/gaussian_2d_fusion_unit.sv
// ----------------------------------------------------------------------------
// gaussian_2d_fusion_unit
// Fuses two 2D Gaussian estimates in information form, signed Q16.16.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not stalled; three banks
// of four restoring dividers, 10 stages each (two banks on the inputs, one on the
// information sum), set the depth.
// Stages move independently, so bubbles close up under output stall.
// Reset clears the stage valid bits only; the datapath registers are not reset.
module gaussian_2d_fusion_unit (
	input  logic              clk,
	input  logic              arst_n,
	g2f_est_if.sink           est,
	g2f_fused_if.source       fused
);
	import g2f_pkg::*;

	localparam int NST = ST_OUT;

	logic [NST:1]   vld_q;
	logic [NST+1:1] rdy;
	logic [NST:1]   vin;
	side_t          side_q [1:NST];
	side_t          side_n [1:NST];

	det_t           det1, det2, detl;
	num_t           num1 [4];
	num_t           num2 [4];
	num_t           nump [4];
	mat_t           inv1, inv2, invp;
	logic [3:0]     inv1_sat, inv2_sat, invp_sat;
	q_t             a1x, a1y, a2x, a2y, fx, fy;
	logic           mv1_sat, mv2_sat, fsat;

	// per-stage handshake: a stage loads when empty or when its successor moves
	always_comb begin
		rdy[NST+1] = fused.ready;
		for (int k = NST; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		vin[1] = est.valid;
		for (int k = 2; k <= NST; k++) begin
			vin[k] = vld_q[k-1];
		end
	end

	assign est.ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NST; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	// input determinants
	g2f_det u_det1 (
		.clk(clk), .en(rdy[ST_DET:1]),
		.a(est.data.first_cov_xx), .b(est.data.first_cov_xy),
		.c(est.data.first_cov_yx), .d(est.data.first_cov_yy),
		.det(det1)
	);

	g2f_det u_det2 (
		.clk(clk), .en(rdy[ST_DET:1]),
		.a(est.data.second_cov_xx), .b(est.data.second_cov_xy),
		.c(est.data.second_cov_yx), .d(est.data.second_cov_yy),
		.det(det2)
	);

	// adjugate entries feed the dividers
	always_comb begin
		num1[0] = NUMW'($signed(side_q[ST_DET].c1[3]));
		num1[1] = -NUMW'($signed(side_q[ST_DET].c1[1]));
		num1[2] = -NUMW'($signed(side_q[ST_DET].c1[2]));
		num1[3] = NUMW'($signed(side_q[ST_DET].c1[0]));
		num2[0] = NUMW'($signed(side_q[ST_DET].c2[3]));
		num2[1] = -NUMW'($signed(side_q[ST_DET].c2[1]));
		num2[2] = -NUMW'($signed(side_q[ST_DET].c2[2]));
		num2[3] = NUMW'($signed(side_q[ST_DET].c2[0]));
		nump[0] = NUMW'($signed(side_q[ST_V].l[3]));
		nump[1] = -NUMW'($signed(side_q[ST_V].l[1]));
		nump[2] = -NUMW'($signed(side_q[ST_V].l[2]));
		nump[3] = NUMW'($signed(side_q[ST_V].l[0]));
	end

	for (genvar k = 0; k < 4; k++) begin : g_div
		g2f_div u_div1 (
			.clk(clk), .en(rdy[ST_INV:ST_DET+1]),
			.num(num1[k]), .den(det1), .res(inv1[k]), .sat(inv1_sat[k])
		);
		g2f_div u_div2 (
			.clk(clk), .en(rdy[ST_INV:ST_DET+1]),
			.num(num2[k]), .den(det2), .res(inv2[k]), .sat(inv2_sat[k])
		);
		g2f_div u_divp (
			.clk(clk), .en(rdy[ST_P:ST_V+1]),
			.num(nump[k]), .den(detl), .res(invp[k]), .sat(invp_sat[k])
		);
	end

	// information vectors of both estimates
	g2f_mv u_mv1 (
		.clk(clk), .en(rdy[ST_MV:ST_L]), .m(inv1),
		.x(side_q[ST_INV].m1x), .y(side_q[ST_INV].m1y),
		.ox(a1x), .oy(a1y), .sat(mv1_sat)
	);

	g2f_mv u_mv2 (
		.clk(clk), .en(rdy[ST_MV:ST_L]), .m(inv2),
		.x(side_q[ST_INV].m2x), .y(side_q[ST_INV].m2y),
		.ox(a2x), .oy(a2y), .sat(mv2_sat)
	);

	// determinant of the information sum
	g2f_det u_detl (
		.clk(clk), .en(rdy[ST_V:ST_MV]),
		.a(side_q[ST_L].l[0]), .b(side_q[ST_L].l[1]),
		.c(side_q[ST_L].l[2]), .d(side_q[ST_L].l[3]),
		.det(detl)
	);

	// fused mean
	g2f_mv u_mvp (
		.clk(clk), .en(rdy[ST_OUT:ST_P+1]), .m(invp),
		.x(side_q[ST_P].vx), .y(side_q[ST_P].vy),
		.ox(fx), .oy(fy), .sat(fsat)
	);

	// side values: advance, and fold in results where they land
	always_comb begin
		sat_t ls [4];
		sat_t svx, svy;
		side_n[1]      = '0;
		side_n[1].m1x  = est.data.first_mean_x;
		side_n[1].m1y  = est.data.first_mean_y;
		side_n[1].m2x  = est.data.second_mean_x;
		side_n[1].m2y  = est.data.second_mean_y;
		side_n[1].c1   = {est.data.first_cov_yy, est.data.first_cov_yx,
			est.data.first_cov_xy, est.data.first_cov_xx};
		side_n[1].c2   = {est.data.second_cov_yy, est.data.second_cov_yx,
			est.data.second_cov_xy, est.data.second_cov_xx};
		for (int k = 2; k <= NST; k++) begin
			side_n[k] = side_q[k-1];
		end

		side_n[ST_DET+1].sing = (det1 == '0) || (det2 == '0);

		for (int k = 0; k < 4; k++) begin
			ls[k] = sat32(SUMW'($signed(inv1[k])) + SUMW'($signed(inv2[k])));
			side_n[ST_L].l[k] = ls[k].val;
		end
		side_n[ST_L].bad = side_q[ST_INV].bad | (|inv1_sat) | (|inv2_sat) |
			ls[0].sat | ls[1].sat | ls[2].sat | ls[3].sat;

		svx = sat32(SUMW'(a1x) + SUMW'(a2x));
		svy = sat32(SUMW'(a1y) + SUMW'(a2y));
		side_n[ST_V].vx  = svx.val;
		side_n[ST_V].vy  = svy.val;
		side_n[ST_V].bad = side_q[ST_MV].bad | mv1_sat | mv2_sat | svx.sat | svy.sat;

		side_n[ST_V+1].sing = side_q[ST_V].sing || (detl == '0);

		side_n[ST_P+1].p   = invp;
		side_n[ST_P+1].bad = side_q[ST_P].bad | (|invp_sat);
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= NST; k++) begin
			if (rdy[k]) begin
				side_q[k] <= side_n[k];
			end
		end
	end

	// drive the result word; a singular matrix zeroes every value
	always_comb begin
		fused.valid = vld_q[NST];
		if (side_q[NST].sing) begin
			fused.data              = '0;
			fused.data.bad_result   = 1'b1;
		end else begin
			fused.data.fused_mean_x = fx;
			fused.data.fused_mean_y = fy;
			fused.data.fused_cov_xx = side_q[NST].p[0];
			fused.data.fused_cov_xy = side_q[NST].p[1];
			fused.data.fused_cov_yx = side_q[NST].p[2];
			fused.data.fused_cov_yy = side_q[NST].p[3];
			fused.data.bad_result   = side_q[NST].bad | fsat;
		end
	end

	// an empty first stage always takes a word
	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[1] |-> est.ready)
		else $error("input not ready with empty first stage");

	// words in flight change only by accepted and delivered words
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(vld_q) == $past($countones(vld_q)) +
			$past(int'(est.valid && est.ready)) - $past(int'(fused.valid && fused.ready)))
		else $error("word lost or duplicated in pipeline");

	// a full pipeline under output stall must refuse input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !fused.ready |-> !est.ready)
		else $error("input accepted into a full stalled pipeline");

endmodule

>>> sim/gaussian_2d_fusion_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_2d_fusion_unit_tb
// Drives estimate pairs into the fusion pipeline with random gaps on both
// sides. Each fused word is compared against a Q16.16 predictor.
// ----------------------------------------------------------------------------
module gaussian_2d_fusion_unit_tb;
	import g2f_pkg::*;

	localparam int  N_DIRECTED = 14;
	localparam int  N_RANDOM   = 1950;
	localparam int  DRAIN      = 60;
	localparam longint LIMIT   = 400000;

	logic clk;
	logic arst_n;
	g2f_est_if   est();
	g2f_fused_if fused();

	gaussian_2d_fusion_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.est(est),
		.fused(fused)
	);

	fused_t pending_fusions[$];
	int     err_cnt;
	longint cyc;
	bit     no_idle;
	int     rx_idle;

	// directed rows; typed-in result where obvious, else predicted
	est_t   dir_in[N_DIRECTED];
	fused_t dir_out[N_DIRECTED];
	bit     dir_known[N_DIRECTED];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc > LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Q16.16 multiply, rounded to nearest, ties up
	function automatic longint qmul_rnd(longint a, longint b);
		return (a * b + 64'sd32768) >>> 16;
	endfunction

	function automatic longint clamp32(longint v, ref bit bad);
		if (v > 64'sd2147483647) begin
			bad = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			bad = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// closed-form 2x2 inverse; returns 0 if the determinant is zero
	function automatic bit invert2(input longint m[4], output longint r[4], ref bit bad);
		longint det;
		det = qmul_rnd(m[0], m[3]) - qmul_rnd(m[1], m[2]);
		if (det == 0)
			return 1'b0;
		r[0] = clamp32((m[3] * 65536) / det, bad);
		r[1] = clamp32((-m[1] * 65536) / det, bad);
		r[2] = clamp32((-m[2] * 65536) / det, bad);
		r[3] = clamp32((m[0] * 65536) / det, bad);
		return 1'b1;
	endfunction

	function automatic void mat_vec(input longint m[4], input longint x, input longint y,
			output longint ox, output longint oy, ref bit bad);
		ox = clamp32(qmul_rnd(m[0], x) + qmul_rnd(m[1], y), bad);
		oy = clamp32(qmul_rnd(m[2], x) + qmul_rnd(m[3], y), bad);
	endfunction

	function automatic fused_t fuse_estimates(est_t e);
		longint c1[4], c2[4], i1[4], i2[4], lsum[4], p[4];
		longint ax, ay, bx, by, vx, vy, fx, fy;
		bit bad;
		fused_t r;
		bad = 1'b0;
		r = '0;
		c1[0] = e.first_cov_xx;  c1[1] = e.first_cov_xy;
		c1[2] = e.first_cov_yx;  c1[3] = e.first_cov_yy;
		c2[0] = e.second_cov_xx; c2[1] = e.second_cov_xy;
		c2[2] = e.second_cov_yx; c2[3] = e.second_cov_yy;
		if (!invert2(c1, i1, bad) || !invert2(c2, i2, bad)) begin
			r.bad_result = 1'b1;
			return r;
		end
		for (int k = 0; k < 4; k++)
			lsum[k] = clamp32(i1[k] + i2[k], bad);
		if (!invert2(lsum, p, bad)) begin
			r.bad_result = 1'b1;
			return r;
		end
		mat_vec(i1, longint'(e.first_mean_x), longint'(e.first_mean_y), ax, ay, bad);
		mat_vec(i2, longint'(e.second_mean_x), longint'(e.second_mean_y), bx, by, bad);
		vx = clamp32(ax + bx, bad);
		vy = clamp32(ay + by, bad);
		mat_vec(p, vx, vy, fx, fy, bad);
		r.fused_mean_x = q_t'(fx);
		r.fused_mean_y = q_t'(fy);
		r.fused_cov_xx = q_t'(p[0]);
		r.fused_cov_xy = q_t'(p[1]);
		r.fused_cov_yx = q_t'(p[2]);
		r.fused_cov_yy = q_t'(p[3]);
		r.bad_result   = bad;
		return r;
	endfunction

	function automatic est_t diag_pair(q_t mx, q_t my, q_t v1, q_t nx, q_t ny, q_t v2);
		est_t e;
		e = '0;
		e.first_mean_x = mx;  e.first_mean_y = my;
		e.first_cov_xx = v1;  e.first_cov_yy = v1;
		e.second_mean_x = nx; e.second_mean_y = ny;
		e.second_cov_xx = v2; e.second_cov_yy = v2;
		return e;
	endfunction

	// random covariance, mostly well-conditioned, sometimes wild or broken
	function automatic est_t random_pair();
		est_t e;
		int sel;
		e = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			e.first_mean_x  = $signed($urandom) >>> $urandom_range(0, 12);
			e.first_mean_y  = $signed($urandom) >>> $urandom_range(0, 12);
			e.second_mean_x = $signed($urandom) >>> $urandom_range(0, 12);
			e.second_mean_y = $signed($urandom) >>> $urandom_range(0, 12);
			e.first_cov_xx  = $urandom_range(32'h0000_4000, 32'h0040_0000);
			e.first_cov_yy  = $urandom_range(32'h0000_4000, 32'h0040_0000);
			e.second_cov_xx = $urandom_range(32'h0000_4000, 32'h0040_0000);
			e.second_cov_yy = $urandom_range(32'h0000_4000, 32'h0040_0000);
			e.first_cov_xy  = $signed($urandom) >>> $urandom_range(14, 24);
			e.first_cov_yx  = (sel < 5) ? e.first_cov_xy : $signed($urandom) >>> 20;
			e.second_cov_xy = $signed($urandom) >>> $urandom_range(14, 24);
			e.second_cov_yx = (sel < 5) ? e.second_cov_xy : $signed($urandom) >>> 20;
		end else if (sel == 7) begin
			// rank-deficient first covariance
			e.first_cov_xy = e.first_cov_xx;
			e.first_cov_yx = e.first_cov_yy;
			e.first_cov_yy = e.first_cov_xx;
			e.first_cov_yx = e.first_cov_xx;
		end
		return e;
	endfunction

	task automatic send_word(est_t e);
		int gap;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			est.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		est.data  <= e;
		est.valid <= 1'b1;
		pending_fusions.push_back(fuse_estimates(e));
		do @(posedge clk); while (!est.ready);
	endtask

	// receiver: random stall bursts, compare each accepted word
	always @(posedge clk or negedge arst_n) begin
		fused_t want;
		if (!arst_n) begin
			fused.ready <= 1'b0;
			rx_idle     <= 0;
		end else begin
			if (fused.valid && fused.ready) begin
				if (pending_fusions.size() == 0) begin
					$display("%0t: unexpected fused word %h", $time, fused.data);
					err_cnt++;
				end else begin
					want = pending_fusions.pop_front();
					if (fused.data !== want) begin
						$display("%0t: mismatch expected %h actual %h", $time, want,
							fused.data);
						err_cnt++;
					end
				end
			end
			if (rx_idle > 0) begin
				rx_idle     <= rx_idle - 1;
				fused.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				rx_idle     <= $urandom_range(0, 13);
				fused.ready <= 1'b0;
			end else begin
				fused.ready <= 1'b1;
			end
		end
	end

	initial begin
		est_t e;
		err_cnt  = 0;
		no_idle  = 1'b0;
		arst_n   = 1'b0;
		est.valid = 1'b0;
		est.data  = '0;

		// directed rows
		dir_in[0] = '0;                             // all zero: singular
		dir_in[1] = diag_pair(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000,
			32'sh0003_0000, 32'sh0004_0000, 32'sh0001_0000);
		dir_in[2] = diag_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000);
		dir_in[3] = diag_pair(0, 0, 32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFF);
		dir_in[4] = diag_pair(0, 0, 32'sh8000_0000, 0, 0, 32'sh8000_0000);
		dir_in[5] = diag_pair(0, 0, 32'sh0000_0001, 0, 0, 32'sh0000_0001);
		dir_in[6] = diag_pair(32'sh0001_0000, 0, 32'sh0001_0000, 0, 0, 0);
		dir_in[7] = diag_pair(32'sh0001_0000, 0, 32'sh0001_0000,
			32'sh0001_0000, 0, 32'shFFFF_0000);         // inverses cancel
		dir_in[8] = diag_pair(32'sh0001_0000, 32'shFFFF_0000, 32'sh0002_0000,
			32'sh0003_0000, 32'sh0001_0000, 32'sh0000_8000);
		dir_in[8].first_cov_xy = 32'sh0000_4000;      // asymmetric
		dir_in[8].first_cov_yx = 32'shFFFF_C000;
		dir_in[9] = '1;
		dir_in[10] = {12{32'h5555_5555}};
		dir_in[11] = {12{32'hAAAA_AAAA}};
		dir_in[12] = diag_pair(32'sh0010_0000, 32'sh0010_0000, 32'sh0000_0100,
			32'sh0010_0000, 32'sh0010_0000, 32'sh0000_0100);
		dir_in[13] = diag_pair(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000,
			32'sh0004_0000, 32'sh0004_0000, 32'sh0002_0000);
		foreach (dir_known[i])
			dir_known[i] = 1'b0;
		dir_out[0] = '0;
		dir_out[0].bad_result = 1'b1;
		dir_known[0] = 1'b1;
		// unit covariances fuse to half identity, mean is the average
		dir_out[1] = {32'sh0002_0000, 32'sh0003_0000, 32'sh0000_8000, 32'sh0, 32'sh0,
			32'sh0000_8000, 1'b0};
		dir_known[1] = 1'b1;
		dir_out[6] = dir_out[0];
		dir_known[6] = 1'b1;
		dir_out[7] = dir_out[0];
		dir_known[7] = 1'b1;
		dir_out[13] = {32'sh0003_0000, 32'sh0003_0000, 32'sh0001_0000, 32'sh0, 32'sh0,
			32'sh0001_0000, 1'b0};
		dir_known[13] = 1'b1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, typed-in rows checked against the predictor too
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (dir_known[i] && fuse_estimates(dir_in[i]) !== dir_out[i]) begin
				$display("%0t: row %0d expected %h actual %h", $time, i, dir_out[i],
					fuse_estimates(dir_in[i]));
				err_cnt++;
			end
			send_word(dir_in[i]);
		end

		// hold off until the pipeline has drained
		est.valid <= 1'b0;
		while (pending_fusions.size() != 0)
			@(posedge clk);

		// random part; last stretch runs with no idling
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 200)
				no_idle = 1'b1;
			e = random_pair();
			send_word(e);
		end
		est.valid <= 1'b0;

		while (pending_fusions.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
